FILE: rtl/core/ltws_pkg.sv
// Shared constants, types and helper functions for the line tokenizer.
package ltws_pkg;

  // Columns saturate at this value; token start columns stop one below it.
  localparam int unsigned MAX_COLUMNS = 4096;

  localparam int unsigned CH_W    = 8;
  localparam int unsigned COL_W   = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned START_W = $clog2(MAX_COLUMNS);
  localparam int unsigned LINE_W  = 16;
  localparam int unsigned KIND_W  = 2;

  localparam int unsigned RES_BITS    = LINE_W + START_W + COL_W;
  localparam int unsigned OUT_TDATA_W = ((RES_BITS + 7) / 8) * 8;

  localparam logic [COL_W-1:0]   MAX_COL_C    = COL_W'(MAX_COLUMNS);
  localparam logic [START_W-1:0] LAST_START_C = START_W'(MAX_COLUMNS - 1);
  localparam logic [LINE_W-1:0]  LINE_MAX_C   = {LINE_W{1'b1}};
  localparam logic [LINE_W-1:0]  LINE_FIRST_C = LINE_W'(1);

  localparam logic [CH_W-1:0] CHAR_HASH   = 8'h23;
  localparam logic [CH_W-1:0] CHAR_QUOTE  = 8'h22;
  localparam logic [CH_W-1:0] CHAR_BSLASH = 8'h5C;
  localparam logic [CH_W-1:0] CHAR_SPACE  = 8'h20;
  localparam logic [CH_W-1:0] CHAR_TAB    = 8'h09;
  localparam logic [CH_W-1:0] CHAR_CR     = 8'h0D;

  typedef enum logic [KIND_W-1:0] {
    KIND_WORD   = 2'd0,
    KIND_STRING = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  // One token result as produced by the lexer core.
  typedef struct packed {
    logic               valid;
    kind_e              kind;
    logic [LINE_W-1:0]  line_no;
    logic [START_W-1:0] start_col;
    logic [COL_W-1:0]   end_col;
  } ltws_result_t;

  // Whitespace is the space and the control bytes from tab to carriage return.
  function automatic logic is_blank(input logic [CH_W-1:0] c);
    return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

endpackage

FILE: rtl/core/line_tokenizer_with_strings_unit.sv
// Top level of the streaming line tokenizer with quoted strings.
//
// The block takes one character item per cycle on the slave stream and reports
// each finished token on the master stream. An item carries a character byte in
// tdata, or an end-of-line mark in tlast (the byte is then ignored). Whitespace
// separates words, a '#' outside a string starts a comment that runs to the end
// of the line, and a '"' at the start of a token opens a string in which a
// backslash escapes the next byte; the string token includes its closing quote.
// Each token result gives its kind in tuser and its line number, start column
// and end column (one past its last byte) in tdata. Columns saturate at 4096
// and line numbers at 65535. A string still open at the end of its line
// produces one error result, after which the block keeps accepting items but
// drops them until reset. The block sustains one item per cycle while results
// are taken: an item is held in the input register and its token, if any, is
// written to the result register when the item moves on, and from there it is
// offered on the master stream. The rate is set by the update of the lexer
// state (mode, column, token start and line), which each item reads and writes.
// The input side stalls only when the result register is full and not taken.
module line_tokenizer_with_strings_unit import ltws_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Slave stream: one character or end-of-line mark per item.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [CH_W-1:0]        s_axis_tdata,   // [7:0] ch
  input  logic                   s_axis_tlast,   // line_end
  // Master stream: at most one token result per item.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [15:0] line_no, [27:16] start_col,
                                                 // [40:28] end_col, rest zero
  output logic [KIND_W-1:0]      m_axis_tuser    // [1:0] kind
);

  // Input register stage.
  logic            in_vld_q, in_vld_d;
  logic [CH_W-1:0] ch_q;
  logic            eol_q;

  // Result register stage.
  logic               out_vld_q, out_vld_d;
  kind_e              kind_q;
  logic [LINE_W-1:0]  line_q;
  logic [START_W-1:0] scol_q;
  logic [COL_W-1:0]   ecol_q;

  ltws_result_t lex_res;
  logic         lex_halted;
  logic         advance;
  logic         in_take;

  // The item in the input register moves on whenever the result register is
  // free or being emptied in this cycle.
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  ltws_lexer u_lexer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .ch_i       (ch_q),
    .line_end_i (eol_q),
    .res_o      (lex_res),
    .halted_o   (lex_halted)
  );

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = lex_res.valid;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      ch_q  <= s_axis_tdata;
      eol_q <= s_axis_tlast;
    end
    if (advance && lex_res.valid) begin
      kind_q <= lex_res.kind;
      line_q <= lex_res.line_no;
      scol_q <= lex_res.start_col;
      ecol_q <= lex_res.end_col;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = kind_q;
  assign m_axis_tdata  = OUT_TDATA_W'({ecol_q, scol_q, line_q});

`ifndef SYNTH
  // A halted lexer never produces another token.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    lex_halted |-> !lex_res.valid)
    else $error("token produced while halted");

  // Every token spans at least one column.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[40:28] > {1'b0, m_axis_tdata[27:16]}))
    else $error("token end column not past start column");

  // Line numbers count from one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[15:0] != '0))
    else $error("token reported on line zero");

  // A result enters the output register only from an item that moved on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!$past(out_vld_q) && out_vld_q) |-> $past(advance && lex_res.valid))
    else $error("result appeared without a source item");
`endif

endmodule

FILE: rtl/core/ltws_lexer.sv
// Lexer core: mode, column, token start and line registers with next-state logic.
module ltws_lexer import ltws_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [CH_W-1:0]  ch_i,
  input  logic             line_end_i,
  output ltws_result_t     res_o,
  output logic             halted_o
);

  typedef enum logic [5:0] {
    MODE_BETWEEN = 6'b000001,
    MODE_WORD    = 6'b000010,
    MODE_STRING  = 6'b000100,
    MODE_ESCAPE  = 6'b001000,
    MODE_COMMENT = 6'b010000,
    MODE_HALTED  = 6'b100000
  } mode_e;

  mode_e              mode_q, mode_d;
  logic [COL_W-1:0]   column_q, column_d;
  logic [START_W-1:0] start_q, start_d;
  logic [LINE_W-1:0]  line_q, line_d;

  logic [COL_W-1:0]   next_col;
  logic [START_W-1:0] open_col;
  logic               blank;

  assign next_col = (column_q < MAX_COL_C) ? column_q + COL_W'(1) : MAX_COL_C;
  assign open_col = (column_q < COL_W'(MAX_COLUMNS - 1)) ? column_q[START_W-1:0]
                                                         : LAST_START_C;
  assign blank    = is_blank(ch_i);
  assign halted_o = (mode_q == MODE_HALTED);

  always_comb begin
    mode_d          = mode_q;
    column_d        = column_q;
    start_d         = start_q;
    line_d          = line_q;
    res_o           = '0;
    res_o.kind      = KIND_WORD;
    res_o.line_no   = line_q;
    res_o.start_col = start_q;
    res_o.end_col   = column_q;

    if (step_i && (mode_q != MODE_HALTED)) begin
      if (line_end_i) begin
        if ((mode_q == MODE_STRING) || (mode_q == MODE_ESCAPE)) begin
          // A string left open at the end of its line is fatal.
          res_o.valid = 1'b1;
          res_o.kind  = KIND_ERROR;
          mode_d      = MODE_HALTED;
        end else begin
          res_o.valid = (mode_q == MODE_WORD);
          line_d      = (line_q < LINE_MAX_C) ? line_q + LINE_W'(1) : LINE_MAX_C;
          column_d    = '0;
          mode_d      = MODE_BETWEEN;
        end
      end else begin
        column_d = next_col;
        unique case (mode_q)
          MODE_BETWEEN: begin
            if (ch_i == CHAR_HASH) begin
              mode_d = MODE_COMMENT;
            end else if (!blank) begin
              start_d = open_col;
              mode_d  = (ch_i == CHAR_QUOTE) ? MODE_STRING : MODE_WORD;
            end
          end
          MODE_WORD: begin
            if ((ch_i == CHAR_HASH) || blank) begin
              res_o.valid = 1'b1;
              mode_d      = (ch_i == CHAR_HASH) ? MODE_COMMENT : MODE_BETWEEN;
            end
          end
          MODE_STRING: begin
            if (ch_i == CHAR_BSLASH) begin
              mode_d = MODE_ESCAPE;
            end else if (ch_i == CHAR_QUOTE) begin
              // The closing quote belongs to the token.
              res_o.valid   = 1'b1;
              res_o.kind    = KIND_STRING;
              res_o.end_col = next_col;
              mode_d        = MODE_BETWEEN;
            end
          end
          MODE_ESCAPE: begin
            mode_d = MODE_STRING;
          end
          default: begin
            mode_d = mode_q;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_BETWEEN;
      column_q <= '0;
      start_q  <= '0;
      line_q   <= LINE_FIRST_C;
    end else begin
      mode_q   <= mode_d;
      column_q <= column_d;
      start_q  <= start_d;
      line_q   <= line_d;
    end
  end

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the streaming line tokenizer with quoted strings.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ltws_pkg::*;

  // Cycles with no item moving on either side before the run is declared hung.
  localparam int STALL_LIMIT = 1000;

  // One token as it travels on the result stream.
  typedef struct packed {
    kind_e              kind;
    logic [LINE_W-1:0]  line_no;
    logic [START_W-1:0] start_col;
    logic [COL_W-1:0]   end_col;
  } token_t;

  // One row of the opening stimulus: the item and, where marked, its token.
  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            eol;
    logic            typed;
    token_t          tok;
  } step_row_t;

  // Lexer modes of the predictor.
  typedef enum logic [2:0] {
    LX_BETWEEN,
    LX_WORD,
    LX_STRING,
    LX_ESCAPE,
    LX_COMMENT,
    LX_HALTED
  } lex_mode_e;

  localparam token_t NO_TOKEN = '0;

  // Opening rows. Line 1 covers words with the byte extremes and a comment
  // that swallows a quote. Line 2 covers a string with an escaped quote and a
  // hash inside it, a word that starts right after the closing quote and holds
  // a quote of its own, and the edges of the whitespace range. Then an empty
  // line, a comment-only line and a blank-only line.
  localparam step_row_t OPENING [25] = '{
    '{8'h61,       1'b0, 1'b0, NO_TOKEN},
    '{8'hFF,       1'b0, 1'b0, NO_TOKEN},
    '{CHAR_SPACE,  1'b0, 1'b1, '{KIND_WORD, 16'd1, 12'd0, 13'd2}},
    '{8'h00,       1'b0, 1'b0, NO_TOKEN},
    '{CHAR_HASH,   1'b0, 1'b1, '{KIND_WORD, 16'd1, 12'd3, 13'd4}},
    '{CHAR_QUOTE,  1'b0, 1'b0, NO_TOKEN},
    '{8'h00,       1'b1, 1'b0, NO_TOKEN},
    '{CHAR_QUOTE,  1'b0, 1'b0, NO_TOKEN},
    '{CHAR_BSLASH, 1'b0, 1'b0, NO_TOKEN},
    '{CHAR_QUOTE,  1'b0, 1'b0, NO_TOKEN},
    '{CHAR_HASH,   1'b0, 1'b0, NO_TOKEN},
    '{CHAR_QUOTE,  1'b0, 1'b1, '{KIND_STRING, 16'd2, 12'd0, 13'd5}},
    '{8'h78,       1'b0, 1'b0, NO_TOKEN},
    '{CHAR_QUOTE,  1'b0, 1'b0, NO_TOKEN},
    '{CHAR_TAB,    1'b0, 1'b1, '{KIND_WORD, 16'd2, 12'd5, 13'd7}},
    '{CHAR_CR,     1'b0, 1'b0, NO_TOKEN},
    '{8'h0E,       1'b0, 1'b0, NO_TOKEN},
    '{8'h08,       1'b0, 1'b0, NO_TOKEN},
    '{8'hFF,       1'b1, 1'b1, '{KIND_WORD, 16'd2, 12'd9, 13'd11}},
    '{8'h00,       1'b1, 1'b0, NO_TOKEN},
    '{CHAR_HASH,   1'b0, 1'b0, NO_TOKEN},
    '{8'h41,       1'b1, 1'b0, NO_TOKEN},
    '{CHAR_SPACE,  1'b0, 1'b0, NO_TOKEN},
    '{8'h0C,       1'b0, 1'b0, NO_TOKEN},
    '{8'h00,       1'b1, 1'b0, NO_TOKEN}
  };

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [CH_W-1:0]        s_axis_tdata = '0;   // [7:0] ch
  logic                   s_axis_tlast = 1'b0; // line_end
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // [15:0] line_no, [27:16] start_col,
                                               // [40:28] end_col, rest zero
  logic [KIND_W-1:0]      m_axis_tuser;        // [1:0] kind

  line_tokenizer_with_strings_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predictor state, advanced once per accepted item.
  lex_mode_e          lx_mode  = LX_BETWEEN;
  logic [COL_W-1:0]   lx_col   = '0;
  logic [START_W-1:0] lx_start = '0;
  logic [LINE_W-1:0]  lx_line  = LINE_FIRST_C;

  // Tokens predicted but not yet seen on the result stream, oldest first.
  token_t tokens_due[$];

  int  items_in    = 0;
  int  tokens_seen = 0;
  int  errors      = 0;
  int  stuck       = 0;
  // Idling odds: 0 means no idling, n means a burst starts with chance 1/n.
  int  tx_odds     = 4;
  int  rx_odds     = 4;
  int  rx_hold     = 0;
  int  gap_odds [3] = '{0, 3, 12};
  bit  quiet       = 1'b0;   // set for the closing stretch: no idling at all
  token_t want;

  function automatic bit blank_byte(input logic [CH_W-1:0] c);
    return (c == CHAR_SPACE) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // Advances the predictor by one item and tells whether a token comes out.
  function automatic bit lex_step(input logic [CH_W-1:0] c, input logic eol,
                                  output token_t tok);
    logic [COL_W-1:0] nxt;
    bit hit;
    hit = 1'b0;
    tok = NO_TOKEN;
    if (lx_mode == LX_HALTED) return 1'b0;
    if (eol) begin
      if (lx_mode == LX_WORD) begin
        tok = '{KIND_WORD, lx_line, lx_start, lx_col};
        hit = 1'b1;
      end else if (lx_mode == LX_STRING || lx_mode == LX_ESCAPE) begin
        // An open string at the end of its line is fatal until reset.
        tok = '{KIND_ERROR, lx_line, lx_start, lx_col};
        lx_mode = LX_HALTED;
        return 1'b1;
      end
      if (lx_line != LINE_MAX_C) lx_line = lx_line + 1'b1;
      lx_col  = '0;
      lx_mode = LX_BETWEEN;
      return hit;
    end
    nxt = (lx_col < MAX_COL_C) ? COL_W'(lx_col + 1'b1) : MAX_COL_C;
    case (lx_mode)
      LX_BETWEEN: begin
        if (c == CHAR_HASH) begin
          lx_mode = LX_COMMENT;
        end else if (!blank_byte(c)) begin
          lx_start = (lx_col < COL_W'(LAST_START_C)) ? lx_col[START_W-1:0] : LAST_START_C;
          lx_mode  = (c == CHAR_QUOTE) ? LX_STRING : LX_WORD;
        end
      end
      LX_WORD: begin
        if (c == CHAR_HASH || blank_byte(c)) begin
          tok     = '{KIND_WORD, lx_line, lx_start, lx_col};
          hit     = 1'b1;
          lx_mode = (c == CHAR_HASH) ? LX_COMMENT : LX_BETWEEN;
        end
      end
      LX_STRING: begin
        if (c == CHAR_BSLASH) begin
          lx_mode = LX_ESCAPE;
        end else if (c == CHAR_QUOTE) begin
          // The closing quote belongs to the string.
          tok     = '{KIND_STRING, lx_line, lx_start, nxt};
          hit     = 1'b1;
          lx_mode = LX_BETWEEN;
        end
      end
      LX_ESCAPE: lx_mode = LX_STRING;
      default: ;
    endcase
    lx_col = nxt;
    return hit;
  endfunction

  function automatic logic [CH_W-1:0] pick_blank();
    logic [CH_W-1:0] c;
    c = CH_W'($urandom_range(8, 13));
    return (c == 8'h08) ? CHAR_SPACE : c;
  endfunction

  // A byte that keeps a word going: not blank, not a hash, not a quote.
  function automatic logic [CH_W-1:0] word_byte();
    logic [CH_W-1:0] c;
    do c = CH_W'($urandom_range(0, 255));
    while (blank_byte(c) || c == CHAR_HASH || c == CHAR_QUOTE);
    return c;
  endfunction

  // Any byte, with the bytes that steer the lexer made more likely.
  function automatic logic [CH_W-1:0] spiced_byte();
    case ($urandom_range(0, 7))
      0: return CHAR_QUOTE;
      1: return CHAR_HASH;
      2: return CHAR_BSLASH;
      3: return pick_blank();
      default: return CH_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Offers one item, waits for it to be taken and records what it should cause.
  // A typed row brings its own expected token instead of the predicted one.
  task automatic send(input logic [CH_W-1:0] c, input logic eol,
                      input bit typed = 1'b0, input token_t given = NO_TOKEN);
    token_t tok;
    bit hit;
    if (!quiet && tx_odds != 0 && $urandom_range(1, tx_odds) == 1) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= eol;
    do @(posedge clk_i);
    while (!s_axis_tready);
    items_in++;
    hit = lex_step(c, eol, tok);
    if (typed) tokens_due.insert(tokens_due.size(), given);
    else if (hit) tokens_due.insert(tokens_due.size(), tok);
  endtask

  // Ends the line, first closing any open string so the block never halts here.
  task automatic end_line();
    if (lx_mode == LX_ESCAPE) send(CH_W'($urandom_range(0, 255)), 1'b0);
    if (lx_mode == LX_STRING) send(CHAR_QUOTE, 1'b0);
    send(CH_W'($urandom_range(0, 255)), 1'b1);
  endtask

  // Holds the sender until every predicted token has come out.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i);
    while (tokens_due.size() != 0);
  endtask

  // Most lines are well formed: words, strings with escapes, an optional
  // trailing comment. The rest are noise heavy in quotes, hashes and escapes.
  task automatic random_line();
    int len;
    if ($urandom_range(0, 9) < 7) begin
      repeat ($urandom_range(0, 6)) begin
        repeat ($urandom_range(0, 3)) send(pick_blank(), 1'b0);
        if ($urandom_range(0, 2) == 0) begin
          send(CHAR_QUOTE, 1'b0);
          len = $urandom_range(0, 8);
          repeat (len) begin
            if ($urandom_range(0, 3) == 0) begin
              send(CHAR_BSLASH, 1'b0);
              send(CH_W'($urandom_range(0, 255)), 1'b0);
            end else begin
              send(word_byte(), 1'b0);
            end
          end
          send(CHAR_QUOTE, 1'b0);
        end else begin
          send(word_byte(), 1'b0);
          repeat ($urandom_range(0, 7))
            send(($urandom_range(0, 5) == 0) ? CHAR_QUOTE : word_byte(), 1'b0);
        end
      end
      if ($urandom_range(0, 3) == 0) begin
        send(CHAR_HASH, 1'b0);
        repeat ($urandom_range(0, 6)) send(spiced_byte(), 1'b0);
      end
    end else begin
      repeat ($urandom_range(1, 20)) send(spiced_byte(), 1'b0);
    end
    end_line();
  endtask

  // Result side: random stalls, and every taken token checked in order.
  always @(posedge clk_i) begin
    if (rx_hold != 0) begin
      rx_hold       <= rx_hold - 1;
      m_axis_tready <= 1'b0;
    end else if (!quiet && rx_odds != 0 && $urandom_range(1, rx_odds) == 1) begin
      rx_hold       <= $urandom_range(0, 12);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
    if ($urandom_range(0, 127) == 0) rx_odds <= gap_odds[$urandom_range(0, 2)];

    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      tokens_seen++;
      if (tokens_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected token, kind %0d line %0d cols %0d..%0d", $realtime,
                 m_axis_tuser, m_axis_tdata[LINE_W-1:0],
                 m_axis_tdata[LINE_W+START_W-1:LINE_W], m_axis_tdata[RES_BITS-1:LINE_W+START_W]);
      end else begin
        want = tokens_due.pop_front();
        if (m_axis_tuser != want.kind) begin
          errors++;
          $display("%0t: kind expected %0d actual %0d", $realtime, want.kind, m_axis_tuser);
        end
        if (m_axis_tdata[LINE_W-1:0] != want.line_no) begin
          errors++;
          $display("%0t: line_no expected %0d actual %0d", $realtime, want.line_no,
                   m_axis_tdata[LINE_W-1:0]);
        end
        if (m_axis_tdata[LINE_W+START_W-1:LINE_W] != want.start_col) begin
          errors++;
          $display("%0t: start_col expected %0d actual %0d", $realtime, want.start_col,
                   m_axis_tdata[LINE_W+START_W-1:LINE_W]);
        end
        if (m_axis_tdata[RES_BITS-1:LINE_W+START_W] != want.end_col) begin
          errors++;
          $display("%0t: end_col expected %0d actual %0d", $realtime, want.end_col,
                   m_axis_tdata[RES_BITS-1:LINE_W+START_W]);
        end
      end
    end
  end

  // Watchdog: a correct block never goes this long with nothing moving.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stuck <= 0;
    end else if (stuck == STALL_LIMIT) begin
      $display("%0t: timeout, nothing moved for %0d cycles", $realtime, STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  initial begin : stimulus
    int base;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (OPENING[i]) send(OPENING[i].ch, OPENING[i].eol, OPENING[i].typed, OPENING[i].tok);

    while (items_in < 720) begin
      tx_odds = gap_odds[$urandom_range(0, 2)];
      random_line();
    end

    // Let everything settle once before the second stretch.
    drain();

    base = items_in;
    while (items_in < base + 680) begin
      tx_odds = gap_odds[$urandom_range(0, 2)];
      random_line();
    end
    quiet = 1'b1;
    while (items_in < base + 830) random_line();

    // Unterminated string whose last byte is a backslash: one error token,
    // then the block drops everything that follows.
    send(CHAR_QUOTE, 1'b0);
    send(8'h6B, 1'b0);
    send(CHAR_BSLASH, 1'b0);
    send(CH_W'($urandom_range(0, 255)), 1'b1);
    repeat (6) send(spiced_byte(), 1'($urandom_range(0, 1)));

    drain();
    repeat (8) @(posedge clk_i);

    $display("Covered %0d items: words, strings, escapes, comments, empty and blank lines,",
             items_in);
    $display("stalls on both sides and a fatal open string; %0d tokens seen, %0d mismatches",
             tokens_seen, errors);
    if (errors == 0 && tokens_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/ltws_pkg.sv
rtl/core/ltws_lexer.sv
rtl/core/line_tokenizer_with_strings_unit.sv
tb/testbench.sv
